// File: sv/assert_macros.svh
// assertion macros for the calendar conversion block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: sv/ecal_pkg.sv
// shared types and constants for the calendar conversion block
`default_nettype none
package ecal_pkg;

  typedef logic [31:0] local_sec_t;
  typedef logic [15:0] day_count_t;
  typedef logic [16:0] sec_of_day_t;

  localparam logic [15:0] OFFSET_RESET = 16'd28800;

  // reciprocal constants, exact over the value ranges used
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;  // 1/675, shift 35
  localparam logic [16:0] DAY_SECONDS  = 17'd86400;
  localparam logic [16:0] CYCLE_RECIP  = 17'd91868;     // 1/1461, shift 27
  localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
  localparam logic [17:0] WEEK_RECIP   = 18'd149797;    // 1/7, shift 20
  localparam logic [2:0]  WEEK_DAYS    = 3'd7;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [13:0] HOUR_RECIP   = 14'd9321;      // 1/225, shift 21
  localparam logic [11:0] HOUR_SECONDS = 12'd3600;
  localparam logic [10:0] MIN_RECIP    = 11'd1093;      // 1/15, shift 14
  localparam logic [5:0]  MIN_SECONDS  = 6'd60;

  localparam logic [7:0]  BASE_YEAR    = 8'd70;
  localparam logic [10:0] YEAR1_START  = 11'd365;
  localparam logic [10:0] YEAR2_START  = 11'd730;
  localparam logic [10:0] YEAR3_START  = 11'd1096;

  localparam logic [8:0] MONTH_START_COMMON [0:11] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] MONTH_START_LEAP [0:11] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

endpackage
`default_nettype wire

// File: sv/ecal_day_split.sv
// splits local seconds into whole days and seconds of the day, three stages
`default_nettype none
module ecal_day_split (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire ecal_pkg::local_sec_t local_sec,
  output ecal_pkg::day_count_t      days,
  output ecal_pkg::sec_of_day_t     sod
);

  logic [50:0]          day_prod;
  ecal_pkg::local_sec_t local_a;
  ecal_pkg::day_count_t days_b;
  logic [31:0]          day_sec_b;
  ecal_pkg::local_sec_t local_b;
  ecal_pkg::day_count_t days_next;
  logic [32:0]          day_sec_full;
  logic [31:0]          sod_full;

  always_comb begin
    days_next    = day_prod[50:35];
    day_sec_full = days_next * ecal_pkg::DAY_SECONDS;
    sod_full     = local_b - day_sec_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_prod  <= local_sec[31:7] * ecal_pkg::DAY_RECIP;
      local_a   <= local_sec;
      days_b    <= days_next;
      day_sec_b <= day_sec_full[31:0];
      local_b   <= local_a;
      days      <= days_b;
      sod       <= sod_full[16:0];
    end
  end

endmodule
`default_nettype wire

// File: sv/ecal_date.sv
// year, day of year, month, day of month and weekday from a day count
`default_nettype none
module ecal_date (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire ecal_pkg::day_count_t days,
  output logic [7:0]                years_since_1900,
  output logic [8:0]                day_of_year,
  output logic [3:0]                month_index,
  output logic [4:0]                day_of_month,
  output logic [2:0]                weekday
);

  // stage a
  logic [32:0]          cyc_prod;
  logic [34:0]          wk_prod;
  logic [16:0]          wk_sum;
  ecal_pkg::day_count_t days_a;
  // stage b
  logic [10:0]          dcyc;
  logic [5:0]           cyc;
  logic [2:0]           wday_b;
  // stage c
  logic [7:0]           year_c;
  logic [8:0]           yday_c;
  logic                 leap_c;
  logic [2:0]           wday_c;

  logic [16:0] wk_sum_next;
  logic [5:0]  cyc_next;
  logic [14:0] wq_next;
  logic [16:0] cyc_days;
  logic [15:0] dcyc_full;
  logic [17:0] wk_days;
  logic [16:0] wday_full;
  logic [1:0]  yoff;
  logic [10:0] yday_full;
  logic        leap_next;
  logic [7:0]  year_next;
  logic [3:0]  month_next;
  logic [8:0]  start_sel;
  logic [8:0]  dom_full;

  always_comb begin
    wk_sum_next = {1'b0, days} + {14'd0, ecal_pkg::EPOCH_WEEKDAY};
    cyc_next    = cyc_prod[32:27];
    wq_next     = wk_prod[34:20];
    cyc_days    = cyc_next * ecal_pkg::CYCLE_DAYS;
    dcyc_full   = days_a - cyc_days[15:0];
    wk_days     = wq_next * ecal_pkg::WEEK_DAYS;
    wday_full   = wk_sum - wk_days[16:0];
  end

  // walk the four years of the leap period: 365, 365, 366 and 365 days
  always_comb begin
    leap_next = 1'b0;
    if (dcyc < ecal_pkg::YEAR1_START) begin
      yoff      = 2'd0;
      yday_full = dcyc;
    end else if (dcyc < ecal_pkg::YEAR2_START) begin
      yoff      = 2'd1;
      yday_full = dcyc - ecal_pkg::YEAR1_START;
    end else if (dcyc < ecal_pkg::YEAR3_START) begin
      yoff      = 2'd2;
      yday_full = dcyc - ecal_pkg::YEAR2_START;
      leap_next = 1'b1;
    end else begin
      yoff      = 2'd3;
      yday_full = dcyc - ecal_pkg::YEAR3_START;
    end
    year_next = ecal_pkg::BASE_YEAR + {cyc, 2'b00} + {6'd0, yoff};
  end

  always_comb begin
    month_next = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (leap_c) begin
        if (yday_c >= ecal_pkg::MONTH_START_LEAP[i]) month_next = 4'(i);
      end else begin
        if (yday_c >= ecal_pkg::MONTH_START_COMMON[i]) month_next = 4'(i);
      end
    end
    start_sel = leap_c ? ecal_pkg::MONTH_START_LEAP[month_next]
                       : ecal_pkg::MONTH_START_COMMON[month_next];
    dom_full  = yday_c - start_sel + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyc_prod         <= days * ecal_pkg::CYCLE_RECIP;
      wk_prod          <= wk_sum_next * ecal_pkg::WEEK_RECIP;
      wk_sum           <= wk_sum_next;
      days_a           <= days;
      dcyc             <= dcyc_full[10:0];
      cyc              <= cyc_next;
      wday_b           <= wday_full[2:0];
      year_c           <= year_next;
      yday_c           <= yday_full[8:0];
      leap_c           <= leap_next;
      wday_c           <= wday_b;
      years_since_1900 <= year_c;
      day_of_year      <= yday_c;
      month_index      <= month_next;
      day_of_month     <= dom_full[4:0];
      weekday          <= wday_c;
    end
  end

endmodule
`default_nettype wire

// File: sv/ecal_time.sv
// hour, minute and second from seconds of the day
`default_nettype none
module ecal_time (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire ecal_pkg::sec_of_day_t sod,
  output logic [4:0]                 hour_of_day,
  output logic [5:0]                 minute_of_hour,
  output logic [5:0]                 second_of_minute
);

  logic [26:0]           hour_prod;
  ecal_pkg::sec_of_day_t sod_a;
  logic [4:0]            hour_b;
  logic [11:0]           rem_b;
  logic [20:0]           min_prod;
  logic [11:0]           rem_c;
  logic [4:0]            hour_c;

  logic [4:0]  hour_next;
  logic [16:0] hour_sec;
  logic [16:0] rem_full;
  logic [5:0]  min_next;
  logic [11:0] min_sec;
  logic [11:0] sec_full;

  always_comb begin
    hour_next = hour_prod[25:21];
    hour_sec  = hour_next * ecal_pkg::HOUR_SECONDS;
    rem_full  = sod_a - hour_sec;
    min_next  = min_prod[19:14];
    min_sec   = min_next * ecal_pkg::MIN_SECONDS;
    sec_full  = rem_c - min_sec;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hour_prod        <= sod[16:4] * ecal_pkg::HOUR_RECIP;
      sod_a            <= sod;
      hour_b           <= hour_next;
      rem_b            <= rem_full[11:0];
      min_prod         <= rem_b[11:2] * ecal_pkg::MIN_RECIP;
      rem_c            <= rem_b;
      hour_c           <= hour_b;
      hour_of_day      <= hour_c;
      minute_of_hour   <= min_next;
      second_of_minute <= sec_full[5:0];
    end
  end

endmodule
`default_nettype wire

// File: sv/epoch_seconds_to_calendar.sv
// throughput: one request per cycle unless stalled; the eight-stage pipeline
// moves as one and holds every stage while a result waits under out_stall
// reset clears all valid bits and loads the zone offset with 28800 seconds
`default_nettype none
`include "assert_macros.svh"
module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       years_since_1900,
  output logic [8:0]       day_of_year,
  output logic [3:0]       month_index,
  output logic [4:0]       day_of_month,
  output logic [2:0]       weekday,
  output logic [4:0]       hour_of_day,
  output logic [5:0]       minute_of_hour,
  output logic [5:0]       second_of_minute
);

  localparam int Depth = 8;

  logic [15:0]           zone_offset_seconds;
  logic [Depth-1:0]      valid_pipe;
  ecal_pkg::local_sec_t  local_sec;
  ecal_pkg::day_count_t  days;
  ecal_pkg::sec_of_day_t sod;
  logic                  en;

  assign en        = !(valid_pipe[Depth-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = valid_pipe[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_seconds <= ecal_pkg::OFFSET_RESET;
    end else if (cfg_wr_en) begin
      zone_offset_seconds <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      local_sec <= {1'b0, epoch_seconds} + {16'd0, zone_offset_seconds};
    end
  end

  ecal_day_split u_split (
    .clk       (clk),
    .en        (en),
    .local_sec (local_sec),
    .days      (days),
    .sod       (sod)
  );

  ecal_date u_date (
    .clk              (clk),
    .en               (en),
    .days             (days),
    .years_since_1900 (years_since_1900),
    .day_of_year      (day_of_year),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .weekday          (weekday)
  );

  ecal_time u_time (
    .clk              (clk),
    .en               (en),
    .sod              (sod),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  `ASSERT_IMPLIES(a_time_range, clk, rst, out_valid, hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 && second_of_minute <= 6'd59)
  `ASSERT_IMPLIES(a_date_range, clk, rst, out_valid, month_index <= 4'd11 && day_of_month != 5'd0 && weekday <= 3'd6)
  `ASSERT_IMPLIES(a_year_range, clk, rst, out_valid, day_of_year <= 9'd365 && years_since_1900 >= 8'd70)
  `ASSERT_NEXT(a_hold_pipe, clk, rst, !en, $stable(valid_pipe))

endmodule
`default_nettype wire
